[rtl/tic_pkg.sv]
// Shared types and constants of the triangle isoline crossing unit.
`default_nettype none
package tic_pkg;

  // Reset values of the configuration registers.
  localparam logic [15:0] LevelReset     = 16'd26214;
  localparam logic [31:0] MinHeightReset = 32'd1311;

  // Quotient bits resolved per divider stage, and the number of divider stages.
  localparam int unsigned DivBits   = 4;
  localparam int unsigned DivStages = 32 / DivBits;

  // Register addresses: the index is paddr bit 2.
  localparam logic RegLevel     = 1'b0;
  localparam logic RegMinHeight = 1'b1;

  // One coordinate lane as it moves through the divider stages.
  typedef struct packed {
    logic [31:0] base;  // coordinate of the end above the level
    logic        neg;   // sign of (below - above)
    logic [15:0] den;   // scalar difference along the edge
    logic [15:0] rem;   // partial remainder
    logic [31:0] work;  // dividend bits still to go, quotient bits shifted in
  } lane_t;

endpackage
`default_nettype wire

[rtl/tic_div_stage.sv]
// One stage of the pipelined restoring divider for a coordinate lane.
`default_nettype none
module tic_div_stage (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire tic_pkg::lane_t lane_i,
  output tic_pkg::lane_t     lane_o
);

  tic_pkg::lane_t lane_d, lane_q;

  // Resolve DivBits quotient bits, most significant first.
  always_comb begin
    logic [16:0] trial;
    lane_d = lane_i;
    for (int i = 0; i < int'(tic_pkg::DivBits); i++) begin
      trial = {lane_d.rem, lane_d.work[31]};
      if (trial >= {1'b0, lane_d.den}) begin
        lane_d.rem  = 16'(trial - {1'b0, lane_d.den});
        lane_d.work = {lane_d.work[30:0], 1'b1};
      end else begin
        lane_d.rem  = trial[15:0];
        lane_d.work = {lane_d.work[30:0], 1'b0};
      end
    end
  end

  // Stage register, held while the next stage is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

[rtl/triangle_isoline_crossing_unit.sv]
// Top level of the triangle isoline crossing unit: pipeline and register port.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o    | ax..cz, level_a..level_c
//  out     | output    | out_valid_o / out_stall_i  | keep, has_line, first_*, second_*
//  cfg     | input     | APB psel/penable/pwrite    | contour_level @0, min_height @4
//
// One triangle is accepted per cycle while in_stall_o is low; its result is offered after
// twelve register stages: input, select, multiply, eight divider stages of four quotient
// bits each, and output. Every stage advances when it is empty or its successor advances,
// so bubbles are squeezed out under a stall and nothing is lost or repeated. Reset clears
// the valid bits and loads the register defaults; no clearing pass is needed.
`default_nettype none
module triangle_isoline_crossing_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] ax_i,
  input  wire logic [31:0] ay_i,
  input  wire logic [31:0] az_i,
  input  wire logic [31:0] bx_i,
  input  wire logic [31:0] by_coord_i,
  input  wire logic [31:0] bz_i,
  input  wire logic [31:0] cx_i,
  input  wire logic [31:0] cy_i,
  input  wire logic [31:0] cz_i,
  input  wire logic [15:0] level_a_i,
  input  wire logic [15:0] level_b_i,
  input  wire logic [15:0] level_c_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             keep_o,
  output logic             has_line_o,
  output logic [31:0]      first_x_o,
  output logic [31:0]      first_y_o,
  output logic [31:0]      first_z_o,
  output logic [31:0]      second_x_o,
  output logic [31:0]      second_y_o,
  output logic [31:0]      second_z_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned NumStages = tic_pkg::DivStages + 4;
  localparam int unsigned LastStage = NumStages - 1;
  localparam int unsigned FirstDiv  = 3;

  // Configuration registers.
  logic [15:0] level_q;
  logic [31:0] min_height_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= tic_pkg::LevelReset;
      min_height_q <= tic_pkg::MinHeightReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        tic_pkg::RegLevel:     level_q      <= pwdata[15:0];
        tic_pkg::RegMinHeight: min_height_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tic_pkg::RegLevel:     prdata = {16'b0, level_q};
      tic_pkg::RegMinHeight: prdata = min_height_q;
      default:               prdata = '0;
    endcase
  end

  // Stage valid bits and the advance chain.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[LastStage] = !vld_q[LastStage] || !out_stall_i;
    for (int i = int'(LastStage) - 1; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < int'(NumStages); i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Stage 0: input registers.
  logic [31:0] coord_q [3][3];
  logic [15:0] scal_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      coord_q[0][0] <= ax_i;  coord_q[0][1] <= ay_i;       coord_q[0][2] <= az_i;
      coord_q[1][0] <= bx_i;  coord_q[1][1] <= by_coord_i; coord_q[1][2] <= bz_i;
      coord_q[2][0] <= cx_i;  coord_q[2][1] <= cy_i;       coord_q[2][2] <= cz_i;
      scal_q[0]     <= level_a_i;
      scal_q[1]     <= level_b_i;
      scal_q[2]     <= level_c_i;
    end
  end

  // Stage 1: pick the crossing edges and form differences.
  logic [2:0]  up;
  logic [1:0]  hi [2];
  logic [1:0]  lo [2];
  logic [1:0]  ea [2];
  logic [1:0]  eb [2];
  logic        line_d;
  logic [31:0] base_d [6];
  logic        neg_d  [6];
  logic [31:0] mag_d  [6];
  logic [15:0] num_d  [2];
  logic [15:0] den_d  [2];
  logic [33:0] zsum_d;
  logic [33:0] thr_d;

  always_comb begin
    logic [32:0] diff;
    for (int v = 0; v < 3; v++) begin
      up[v] = scal_q[v] > level_q;
    end
    line_d = (up != 3'b000) && (up != 3'b111);
    // First edge: (one,two) if it crosses, else (one,three).
    if (up[0] != up[1]) begin
      ea[0] = 2'd0; eb[0] = 2'd1;
      if (up[0] != up[2]) begin
        ea[1] = 2'd0; eb[1] = 2'd2;
      end else begin
        ea[1] = 2'd1; eb[1] = 2'd2;
      end
    end else begin
      ea[0] = 2'd0; eb[0] = 2'd2;
      ea[1] = 2'd1; eb[1] = 2'd2;
    end
    for (int p = 0; p < 2; p++) begin
      hi[p]    = up[ea[p]] ? ea[p] : eb[p];
      lo[p]    = up[ea[p]] ? eb[p] : ea[p];
      num_d[p] = scal_q[hi[p]] - level_q;
      den_d[p] = scal_q[hi[p]] - scal_q[lo[p]];
      for (int k = 0; k < 3; k++) begin
        diff = {coord_q[lo[p]][k][31], coord_q[lo[p]][k]}
             - {coord_q[hi[p]][k][31], coord_q[hi[p]][k]};
        base_d[p*3+k] = coord_q[hi[p]][k];
        neg_d[p*3+k]  = diff[32];
        mag_d[p*3+k]  = diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
      end
    end
    zsum_d = {{2{coord_q[0][2][31]}}, coord_q[0][2]}
           + {{2{coord_q[1][2][31]}}, coord_q[1][2]}
           + {{2{coord_q[2][2][31]}}, coord_q[2][2]};
    thr_d  = {min_height_q[31], min_height_q, 1'b0}
           + {{2{min_height_q[31]}}, min_height_q};
  end

  logic [31:0] base1_q [6];
  logic        neg1_q  [6];
  logic [31:0] mag1_q  [6];
  logic [15:0] num1_q  [2];
  logic [15:0] den1_q  [2];
  logic [33:0] zsum1_q;
  logic [33:0] thr1_q;
  logic [NumStages-1:1] line_q;
  logic [NumStages-1:2] keep_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      base1_q   <= base_d;
      neg1_q    <= neg_d;
      mag1_q    <= mag_d;
      num1_q    <= num_d;
      den1_q    <= den_d;
      zsum1_q   <= zsum_d;
      thr1_q    <= thr_d;
    end
  end

  // Stage 2: scale each difference by its numerator.
  tic_pkg::lane_t lane2_d [6];
  tic_pkg::lane_t lane2_q [6];

  always_comb begin
    logic [47:0] prod;
    for (int l = 0; l < 6; l++) begin
      prod = {16'b0, mag1_q[l]} * {32'b0, num1_q[l/3]};
      lane2_d[l].base = base1_q[l];
      lane2_d[l].neg  = neg1_q[l];
      lane2_d[l].den  = den1_q[l/3];
      lane2_d[l].rem  = prod[47:32];
      lane2_d[l].work = prod[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      lane2_q   <= lane2_d;
    end
  end

  // Stages 3 and on: divider pipeline, flags travel beside it.
  tic_pkg::lane_t lane_s [tic_pkg::DivStages+1][6];

  for (genvar l = 0; l < 6; l++) begin : g_lane
    assign lane_s[0][l] = lane2_q[l];
    for (genvar s = 0; s < int'(tic_pkg::DivStages); s++) begin : g_stage
      tic_div_stage u_div (
        .clk_i  (clk_i),
        .en_i   (en[FirstDiv+s]),
        .lane_i (lane_s[s][l]),
        .lane_o (lane_s[s+1][l])
      );
    end
  end

  // Crossing and keep flags: formed in stages 1 and 2, then shifted along.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      line_q[1] <= line_d;
    end
    if (en[2]) begin
      line_q[2] <= line_q[1];
      keep_q[2] <= $signed(zsum1_q) > $signed(thr1_q);
    end
    for (int i = int'(FirstDiv); i < int'(NumStages); i++) begin
      if (en[i]) begin
        line_q[i] <= line_q[i-1];
        keep_q[i] <= keep_q[i-1];
      end
    end
  end

  // Last stage: apply the sign, add the base point, zero when no crossing.
  logic [31:0] res_d [6];
  logic [31:0] res_q [6];

  always_comb begin
    logic [31:0] q;
    for (int l = 0; l < 6; l++) begin
      q = lane_s[tic_pkg::DivStages][l].work;
      res_d[l] = line_q[LastStage-1]
               ? lane_s[tic_pkg::DivStages][l].base
                 + (lane_s[tic_pkg::DivStages][l].neg ? (~q + 32'd1) : q)
               : 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LastStage]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[LastStage];
  assign keep_o      = keep_q[LastStage];
  assign has_line_o  = line_q[LastStage];
  assign first_x_o   = res_q[0];
  assign first_y_o   = res_q[1];
  assign first_z_o   = res_q[2];
  assign second_x_o  = res_q[3];
  assign second_y_o  = res_q[4];
  assign second_z_o  = res_q[5];

  // Checks on the pipeline control and the result.
  a_zero_without_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_line_o) |-> (first_x_o == 32'd0 && first_y_o == 32'd0 &&
      first_z_o == 32'd0 && second_x_o == 32'd0 && second_y_o == 32'd0 &&
      second_z_o == 32'd0))
    else $error("coordinates not zero without a crossing");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld_q[LastStage] && out_stall_i))
    else $error("input stalled while the output can move");

  a_last_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[LastStage] && vld_q[LastStage-1]) |=> vld_q[LastStage])
    else $error("transaction lost entering the output stage");

endmodule
`default_nettype wire
